// ===== hdl/wps_pkg.sv =====
// Package for the waypoint sequencer: field widths, item kinds, queue entry
// layout and the command and status bundles between controller and datapath.
// No dependencies.
package wps_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam logic [30:0] HOLD_RADIUS = 31'd6554;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_POS   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  localparam logic [1:0] WP_PASS = 2'd0;
  localparam logic [1:0] WP_HOLD = 2'd1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] yaw;
    logic [15:0] speed;
    logic [30:0] radius;
    logic        track;
    logic        hold;
    logic [1:0]  wtype;
    logic [31:0] ticks;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic square;
    logic compare;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_test;
    logic advance_more;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/wps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/wps_datapath.sv =====
// Datapath of the waypoint sequencer: queue RAM, target and pose registers,
// arrival distance pipeline, hold timer and result register.
// Depends on wps_pkg and wps_ram.
module wps_datapath #(
  parameter int DEPTH = wps_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  wps_pkg::cmd_t       cmd,
  output wps_pkg::sts_t       sts,
  input  logic [1:0]          kind,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [15:0]  yaw,
  input  logic [15:0]         speed,
  input  logic [30:0]         accept_radius,
  input  logic                track_flag,
  input  logic                hold_flag,
  input  logic [1:0]          wp_type,
  input  logic [31:0]         hold_ticks,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  target_x,
  output logic signed [31:0]  target_y,
  output logic signed [15:0]  target_yaw,
  output logic [15:0]         target_speed,
  output logic [30:0]         target_radius,
  output logic                target_track,
  output logic                target_hold,
  output logic signed [31:0]  prev_x,
  output logic signed [31:0]  prev_y,
  output logic                reached_edge,
  output logic [6:0]          pending,
  output logic                dropped
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]  it_kind;
  logic [31:0] it_x, it_y, it_ticks;
  logic [15:0] it_yaw, it_speed;
  logic [30:0] it_radius;
  logic        it_track, it_hold;
  logic [1:0]  it_type;

  logic [31:0] tg_x, tg_y;
  logic [15:0] tg_yaw, tg_speed;
  logic [30:0] tg_radius;
  logic        tg_track, tg_hold;
  logic [1:0]  hd_type;
  logic [31:0] hd_ticks;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [31:0]   pose_x, pose_y;
  logic [15:0]   pose_yaw;
  logic [31:0]   prv_x, prv_y;
  logic [15:0]   prv_speed;
  logic          reached, reached_b, holding, timer_running, drop_flag;
  logic [31:0]   hold_start, now_ticks;

  logic [30:0] dx, dy;
  logic        in_box;
  logic [61:0] sqx, sqy, r2;

  logic [AW-1:0]      head_inc, tail;
  logic [AW:0]        tail_sum;
  logic               full, moved;
  logic signed [32:0] diff_x, diff_y;
  logic [32:0]        abs_x, abs_y;
  logic [62:0]        dist_sum;
  logic               hit, done;
  logic [31:0]        elapsed;
  logic               ram_we;
  wps_pkg::entry_t    wr_entry, rd_entry;

  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign tail_sum = (AW + 1)'(head) + (AW + 1)'(count);
  assign tail = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                : AW'(tail_sum);
  assign full = (count == CW'(DEPTH));
  assign moved = (it_x != pose_x) || (it_y != pose_y);

  assign diff_x = $signed({it_x[31], it_x}) - $signed({tg_x[31], tg_x});
  assign diff_y = $signed({it_y[31], it_y}) - $signed({tg_y[31], tg_y});
  assign abs_x = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
  assign abs_y = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);

  assign dist_sum = {1'b0, sqx} + {1'b0, sqy};
  assign hit = in_box && (dist_sum <= {1'b0, r2});
  assign elapsed = timer_running ? (now_ticks - hold_start) : 32'd0;

  always_comb begin
    done = 1'b0;
    case (hd_type)
      wps_pkg::WP_PASS: done = hit;
      wps_pkg::WP_HOLD: done = (timer_running || hit) && (elapsed >= hd_ticks);
      default: done = 1'b0;
    endcase
  end

  assign sts.need_test = (it_kind == wps_pkg::KIND_POS) && moved && (count != '0) &&
                         ((hd_type == wps_pkg::WP_PASS) || (hd_type == wps_pkg::WP_HOLD));
  assign sts.advance_more = done && (count != CW'(1));
  assign sts.out_free = !out_valid || !out_stall;

  assign ram_we = cmd.exec && (it_kind == wps_pkg::KIND_ADD) && !full;
  assign wr_entry = '{x: it_x, y: it_y, yaw: it_yaw, speed: it_speed, radius: it_radius,
                      track: it_track, hold: it_hold, wtype: it_type, ticks: it_ticks};

  wps_ram #(
    .WIDTH($bits(wps_pkg::entry_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(tail),
    .wr_data(wr_entry),
    .rd_addr(head_inc),
    .rd_data(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_kind   <= kind;
      it_x      <= pos_x;
      it_y      <= pos_y;
      it_yaw    <= yaw;
      it_speed  <= speed;
      it_radius <= accept_radius;
      it_track  <= track_flag;
      it_hold   <= hold_flag;
      it_type   <= wp_type;
      it_ticks  <= hold_ticks;
    end
    if (cmd.exec) begin
      dx     <= abs_x[30:0];
      dy     <= abs_y[30:0];
      in_box <= (abs_x <= {2'b00, tg_radius}) && (abs_y <= {2'b00, tg_radius});
    end
    if (cmd.square) begin
      sqx <= dx * dx;
      sqy <= dy * dy;
      r2  <= tg_radius * tg_radius;
    end
    if (cmd.emit) begin
      target_x      <= tg_x;
      target_y      <= tg_y;
      target_yaw    <= tg_yaw;
      target_speed  <= tg_speed;
      target_radius <= tg_radius;
      target_track  <= tg_track;
      target_hold   <= tg_hold;
      prev_x        <= prv_x;
      prev_y        <= prv_y;
      reached_edge  <= reached && !reached_b;
      pending       <= 7'(count);
      dropped       <= drop_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tg_x <= '0;
      tg_y <= '0;
      tg_yaw <= '0;
      tg_speed <= '0;
      tg_radius <= wps_pkg::HOLD_RADIUS;
      tg_track <= 1'b0;
      tg_hold <= 1'b1;
      hd_type <= '0;
      hd_ticks <= '0;
      head <= '0;
      count <= '0;
      pose_x <= '0;
      pose_y <= '0;
      pose_yaw <= '0;
      prv_x <= '0;
      prv_y <= '0;
      prv_speed <= '0;
      reached <= 1'b0;
      reached_b <= 1'b0;
      holding <= 1'b1;
      timer_running <= 1'b0;
      drop_flag <= 1'b0;
      hold_start <= '0;
      now_ticks <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec) begin
        drop_flag <= (it_kind == wps_pkg::KIND_ADD) && full;
        case (it_kind)
          wps_pkg::KIND_ADD: begin
            if (!full) begin
              holding <= 1'b0;
              count <= count + CW'(1);
              if (count == '0) begin
                prv_x <= pose_x;
                prv_y <= pose_y;
                tg_x <= it_x;
                tg_y <= it_y;
                tg_yaw <= it_yaw;
                tg_speed <= it_speed;
                tg_radius <= it_radius;
                tg_track <= it_track;
                tg_hold <= it_hold;
                hd_type <= it_type;
                hd_ticks <= it_ticks;
              end
            end
          end
          wps_pkg::KIND_POS: begin
            pose_x <= it_x;
            pose_y <= it_y;
            pose_yaw <= it_yaw;
          end
          wps_pkg::KIND_CLEAR: begin
            count <= '0;
            head <= '0;
            timer_running <= 1'b0;
            if (!holding) begin
              tg_x <= prv_x;
              tg_y <= prv_y;
              tg_speed <= prv_speed;
              tg_yaw <= pose_yaw;
              tg_radius <= wps_pkg::HOLD_RADIUS;
              tg_hold <= 1'b1;
              tg_track <= 1'b0;
              holding <= 1'b1;
            end
          end
          wps_pkg::KIND_TICK: begin
            now_ticks <= now_ticks + 32'd1;
          end
          default: begin
            now_ticks <= now_ticks;
          end
        endcase
      end
      if (cmd.compare) begin
        if (hit) begin
          reached_b <= reached;
          reached <= 1'b1;
        end
        if (hd_type == wps_pkg::WP_HOLD) begin
          if (done) begin
            timer_running <= 1'b0;
          end else if (hit && !timer_running) begin
            hold_start <= now_ticks;
            timer_running <= 1'b1;
          end
        end
        if (done) begin
          prv_x <= tg_x;
          prv_y <= tg_y;
          prv_speed <= tg_speed;
          count <= count - CW'(1);
          if (count == CW'(1)) begin
            head <= '0;
            timer_running <= 1'b0;
            tg_yaw <= pose_yaw;
            tg_radius <= wps_pkg::HOLD_RADIUS;
            tg_hold <= 1'b1;
            tg_track <= 1'b0;
            holding <= 1'b1;
          end else begin
            head <= head_inc;
          end
        end
      end
      if (cmd.load) begin
        tg_x <= rd_entry.x;
        tg_y <= rd_entry.y;
        tg_yaw <= rd_entry.yaw;
        tg_speed <= rd_entry.speed;
        tg_radius <= rd_entry.radius;
        tg_track <= rd_entry.track;
        tg_hold <= rd_entry.hold;
        hd_type <= rd_entry.wtype;
        hd_ticks <= rd_entry.ticks;
        reached <= 1'b0;
        reached_b <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/wps_controller.sv =====
// Controller of the waypoint sequencer: steps each request through execute,
// square and compare on an arrival test, load on an advance, and hand-off.
// Depends on wps_pkg.
module wps_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  wps_pkg::sts_t sts,
  output wps_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SQUARE,
    S_COMPARE,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.exec    = (state == S_EXEC);
    cmd.square  = (state == S_SQUARE);
    cmd.compare = (state == S_COMPARE);
    cmd.load    = (state == S_LOAD);
    cmd.emit    = (state == S_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= sts.need_test ? S_SQUARE : S_EMIT;
        end
        S_SQUARE: begin
          state <= S_COMPARE;
        end
        S_COMPARE: begin
          state <= sts.advance_more ? S_LOAD : S_EMIT;
        end
        S_LOAD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/waypoint_sequencer.sv =====
// Waypoint sequencer top level: joins the controller and the datapath.
// Depends on wps_pkg, wps_controller and wps_datapath.
//
// Each input request is an add, a position update, a clear or a time tick,
// and each request gives exactly one result: the target waypoint, the
// previous waypoint, the arrival edge flag, the queue fill and the drop flag
// as they stand after that request.
// A request is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// Add, clear, tick and position updates that run no arrival test go from
// execute straight to the result hand-off. An arrival test adds the
// squared-distance multipliers and compare, and an advance to a further
// queue entry adds the registered queue RAM read before the result is
// registered. One request is in flight at a time.
// The result sits in an output register, so the next request is taken while
// a result waits; if the receiver keeps stalling, the block holds the next
// result back and stalls its input.
// After reset the queue is empty and the target is a hold at the origin.
module waypoint_sequencer #(
  parameter int QUEUE_DEPTH = wps_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] yaw,
  input  logic [15:0]        speed,
  input  logic [30:0]        accept_radius,
  input  logic               track_flag,
  input  logic               hold_flag,
  input  logic [1:0]         wp_type,
  input  logic [31:0]        hold_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] target_x,
  output logic signed [31:0] target_y,
  output logic signed [15:0] target_yaw,
  output logic [15:0]        target_speed,
  output logic [30:0]        target_radius,
  output logic               target_track,
  output logic               target_hold,
  output logic signed [31:0] prev_x,
  output logic signed [31:0] prev_y,
  output logic               reached_edge,
  output logic [6:0]         pending,
  output logic               dropped
);

  wps_pkg::cmd_t cmd;
  wps_pkg::sts_t sts;

  wps_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  wps_datapath #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .yaw          (yaw),
    .speed        (speed),
    .accept_radius(accept_radius),
    .track_flag   (track_flag),
    .hold_flag    (hold_flag),
    .wp_type      (wp_type),
    .hold_ticks   (hold_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target_x     (target_x),
    .target_y     (target_y),
    .target_yaw   (target_yaw),
    .target_speed (target_speed),
    .target_radius(target_radius),
    .target_track (target_track),
    .target_hold  (target_hold),
    .prev_x       (prev_x),
    .prev_y       (prev_y),
    .reached_edge (reached_edge),
    .pending      (pending),
    .dropped      (dropped)
  );

endmodule

// ===== dv/waypoint_sequencer_checker.sv =====
// Checker for the waypoint sequencer: watches the request and result channels,
// predicts each result from its own copy of the queue state and compares.
// Depends on wps_pkg.
`timescale 1ns / 100ps

module waypoint_sequencer_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] yaw,
  input  logic [15:0]        speed,
  input  logic [30:0]        accept_radius,
  input  logic               track_flag,
  input  logic               hold_flag,
  input  logic [1:0]         wp_type,
  input  logic [31:0]        hold_ticks,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [15:0] target_yaw,
  input  logic [15:0]        target_speed,
  input  logic [30:0]        target_radius,
  input  logic               target_track,
  input  logic               target_hold,
  input  logic signed [31:0] prev_x,
  input  logic signed [31:0] prev_y,
  input  logic               reached_edge,
  input  logic [6:0]         pending,
  input  logic               dropped,
  output int                 errors,
  output int                 waiting
);

  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [15:0] tyaw;
    logic [15:0] tspeed;
    logic [30:0] tradius;
    logic        ttrack;
    logic        thold;
    logic [31:0] px;
    logic [31:0] py;
    logic        edge_flag;
    logic [6:0]  fill;
    logic        drop;
  } status_t;

  wps_pkg::entry_t wq [wps_pkg::QUEUE_DEPTH];
  int              head;
  int              fill_cnt;
  logic [31:0]     pose_xm, pose_ym;
  logic [15:0]     pose_yawm;
  logic [31:0]     last_x, last_y;
  logic [15:0]     last_speed;
  wps_pkg::entry_t aim;
  logic            hit_now, hit_old, parked, timing;
  logic [31:0]     hold_from, tick_now;
  status_t         expected_status[$];

  function automatic longint unsigned mag(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return d < 0 ? longint'(-d) : longint'(d);
  endfunction

  task automatic reset_model();
    head = 0; fill_cnt = 0;
    pose_xm = 0; pose_ym = 0; pose_yawm = 0;
    last_x = 0; last_y = 0; last_speed = 0;
    aim = '0; aim.radius = wps_pkg::HOLD_RADIUS; aim.hold = 1'b1;
    hit_now = 0; hit_old = 0; parked = 1; timing = 0;
    hold_from = 0; tick_now = 0;
  endtask

  task automatic empty_queue();
    fill_cnt = 0; head = 0; timing = 0;
    if (!parked) begin
      aim = '0;
      aim.x = last_x; aim.y = last_y; aim.speed = last_speed;
      aim.yaw = pose_yawm; aim.radius = wps_pkg::HOLD_RADIUS; aim.hold = 1'b1;
      parked = 1;
    end
  endtask

  function automatic logic at_head();
    longint unsigned r, dx, dy;
    r = wq[head].radius;
    dx = mag(wq[head].x, pose_xm);
    dy = mag(wq[head].y, pose_ym);
    if (dx > r || dy > r) return 1'b0;
    if (dx * dx + dy * dy > r * r) return 1'b0;
    hit_old = hit_now; hit_now = 1;
    return 1'b1;
  endfunction

  task automatic step_queue();
    last_x = wq[head].x; last_y = wq[head].y; last_speed = wq[head].speed;
    head = (head + 1) % wps_pkg::QUEUE_DEPTH;
    fill_cnt--;
    if (fill_cnt == 0) begin
      empty_queue();
    end else begin
      aim = wq[head];
      hit_now = 0; hit_old = 0;
    end
  endtask

  task automatic predict_request();
    status_t         s;
    wps_pkg::entry_t e;
    logic            drop, hit, done, moved;
    drop = 0;
    case (wps_pkg::kind_t'(kind))
      wps_pkg::KIND_ADD: begin
        if (fill_cnt >= wps_pkg::QUEUE_DEPTH) begin
          drop = 1;
        end else begin
          e = '{x: pos_x, y: pos_y, yaw: yaw, speed: speed, radius: accept_radius,
                track: track_flag, hold: hold_flag, wtype: wp_type, ticks: hold_ticks};
          wq[(head + fill_cnt) % wps_pkg::QUEUE_DEPTH] = e;
          parked = 0;
          if (fill_cnt == 0) begin
            last_x = pose_xm; last_y = pose_ym; aim = e;
          end
          fill_cnt++;
        end
      end
      wps_pkg::KIND_POS: begin
        moved = (pos_x != pose_xm) || (pos_y != pose_ym);
        pose_xm = pos_x; pose_ym = pos_y; pose_yawm = yaw;
        if (moved && fill_cnt > 0) begin
          done = 0;
          if (wq[head].wtype == wps_pkg::WP_PASS) begin
            done = at_head();
          end else if (wq[head].wtype == wps_pkg::WP_HOLD) begin
            hit = at_head();
            if (hit && !timing) begin
              hold_from = tick_now; timing = 1;
            end
            if (timing && (tick_now - hold_from) >= wq[head].ticks) begin
              timing = 0; done = 1;
            end
          end
          if (done) step_queue();
        end
      end
      wps_pkg::KIND_CLEAR: empty_queue();
      default: tick_now++;
    endcase
    s.tx = aim.x; s.ty = aim.y; s.tyaw = aim.yaw; s.tspeed = aim.speed;
    s.tradius = aim.radius; s.ttrack = aim.track; s.thold = aim.hold;
    s.px = last_x; s.py = last_y; s.edge_flag = hit_now && !hit_old;
    s.fill = fill_cnt[6:0]; s.drop = drop;
    expected_status.insert(expected_status.size(), s);
  endtask

  task automatic compare_result();
    status_t e, a;
    a = '{target_x, target_y, target_yaw, target_speed, target_radius, target_track,
          target_hold, prev_x, prev_y, reached_edge, pending, dropped};
    if (expected_status.size() == 0) begin
      $display("%0t: unexpected result %h", $time, a);
      errors++;
      return;
    end
    e = expected_status.pop_front();
    if (e.tx != a.tx) begin
      $display("%0t: target_x expected %h got %h", $time, e.tx, a.tx); errors++;
    end
    if (e.ty != a.ty) begin
      $display("%0t: target_y expected %h got %h", $time, e.ty, a.ty); errors++;
    end
    if (e.tyaw != a.tyaw) begin
      $display("%0t: target_yaw expected %h got %h", $time, e.tyaw, a.tyaw); errors++;
    end
    if (e.tspeed != a.tspeed) begin
      $display("%0t: target_speed expected %h got %h", $time, e.tspeed, a.tspeed);
      errors++;
    end
    if (e.tradius != a.tradius) begin
      $display("%0t: target_radius expected %h got %h", $time, e.tradius, a.tradius);
      errors++;
    end
    if (e.ttrack != a.ttrack) begin
      $display("%0t: target_track expected %b got %b", $time, e.ttrack, a.ttrack);
      errors++;
    end
    if (e.thold != a.thold) begin
      $display("%0t: target_hold expected %b got %b", $time, e.thold, a.thold); errors++;
    end
    if (e.px != a.px) begin
      $display("%0t: prev_x expected %h got %h", $time, e.px, a.px); errors++;
    end
    if (e.py != a.py) begin
      $display("%0t: prev_y expected %h got %h", $time, e.py, a.py); errors++;
    end
    if (e.edge_flag != a.edge_flag) begin
      $display("%0t: reached_edge expected %b got %b", $time, e.edge_flag, a.edge_flag);
      errors++;
    end
    if (e.fill != a.fill) begin
      $display("%0t: pending expected %0d got %0d", $time, e.fill, a.fill); errors++;
    end
    if (e.drop != a.drop) begin
      $display("%0t: dropped expected %b got %b", $time, e.drop, a.drop); errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      reset_model();
      expected_status.delete();
    end else begin
      if (in_valid && !in_stall) predict_request();
      if (out_valid && !out_stall) compare_result();
    end
    waiting = expected_status.size();
  end

endmodule

// ===== dv/waypoint_sequencer_tb.sv =====
// Testbench top for the waypoint sequencer: clock, reset, request stimulus
// with random gaps and result stalls, and the verdict.
// Depends on wps_pkg, waypoint_sequencer and waypoint_sequencer_checker.
`timescale 1ns / 100ps

module waypoint_sequencer_tb;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         kind = wps_pkg::KIND_TICK;
  logic signed [31:0] pos_x = 0;
  logic signed [31:0] pos_y = 0;
  logic signed [15:0] yaw = 0;
  logic [15:0]        speed = 0;
  logic [30:0]        accept_radius = 0;
  logic               track_flag = 0;
  logic               hold_flag = 0;
  logic [1:0]         wp_type = wps_pkg::WP_PASS;
  logic [31:0]        hold_ticks = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] target_x, target_y, prev_x, prev_y;
  logic signed [15:0] target_yaw;
  logic [15:0]        target_speed;
  logic [30:0]        target_radius;
  logic               target_track, target_hold, reached_edge, dropped;
  logic [6:0]         pending;
  int                 errors, waiting;
  logic               sending = 0;
  logic signed [31:0] near_x = 0, near_y = 0;

  always #10 clk = ~clk;

  waypoint_sequencer DUT (.*);
  waypoint_sequencer_checker u_checker (.*);

  always @(posedge clk) begin
    case ($urandom_range(0, 3))
      0: out_stall <= ($urandom_range(0, 9) < 7);
      1: out_stall <= 1'b0;
      default: out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send(input wps_pkg::kind_t k, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] w, input logic [31:0] v, input logic [31:0] r,
                      input logic [31:0] tr, input logic [31:0] hd, input logic [1:0] ty,
                      input logic [31:0] ht);
    in_valid <= 1'b1;
    kind <= k; pos_x <= x; pos_y <= y; yaw <= w[15:0]; speed <= v[15:0];
    accept_radius <= r[30:0]; track_flag <= tr[0]; hold_flag <= hd[0];
    wp_type <= ty; hold_ticks <= ht;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic gap();
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic add_wp(input logic [31:0] x, input logic [31:0] y, input logic [31:0] r,
                        input logic [1:0] ty, input logic [31:0] ht);
    send(wps_pkg::KIND_ADD, x, y, $urandom, $urandom, r, $urandom, $urandom, ty, ht);
  endtask

  task automatic pose(input logic [31:0] x, input logic [31:0] y);
    send(wps_pkg::KIND_POS, x, y, $urandom, $urandom, $urandom, $urandom, $urandom,
         2'($urandom), $urandom);
  endtask

  task automatic ctl(input wps_pkg::kind_t k);
    send(k, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         2'($urandom), $urandom);
  endtask

  task automatic random_request();
    int          sel;
    logic [31:0] off;
    sel = $urandom_range(0, 99);
    off = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 800)) - 400;
    if (sel < 30) begin
      near_x = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
      near_y = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
      add_wp(near_x, near_y,
             $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 600),
             $urandom_range(0, 9) == 0 ? 2'($urandom_range(2, 3)) :
                                         2'($urandom_range(0, 1)),
             $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 4));
    end else if (sel < 70) begin
      pose(near_x + off, near_y + $signed($urandom_range(0, 800)) - 400);
    end else if (sel < 90) begin
      ctl(wps_pkg::KIND_TICK);
    end else if (sel < 95) begin
      pose(pos_x, pos_y);
    end else begin
      ctl(wps_pkg::KIND_CLEAR);
    end
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    pose(32'h7fff_ffff, 32'h8000_0000);
    add_wp(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, wps_pkg::WP_PASS, 0);
    pose(32'h8000_0000, 32'h7fff_ffff);
    add_wp(100, 100, 0, wps_pkg::WP_HOLD, 2);
    add_wp(200, 200, 50, wps_pkg::WP_PASS, 0);
    pose(100, 100);
    pose(100, 100);
    ctl(wps_pkg::KIND_TICK);
    pose(101, 100);
    ctl(wps_pkg::KIND_TICK);
    pose(100, 100);
    pose(230, 230);
    pose(235, 240);
    add_wp(0, 0, 10, 2'd3, 32'hffff_ffff);
    pose(0, 0);
    pose(1, 1);
    ctl(wps_pkg::KIND_CLEAR);
    ctl(wps_pkg::KIND_CLEAR);
    for (n = 0; n < wps_pkg::QUEUE_DEPTH + 2; n++) begin
      add_wp($urandom, $urandom, $urandom, 2'd2, $urandom);
    end
    ctl(wps_pkg::KIND_CLEAR);
    add_wp(5, 5, 3, wps_pkg::WP_HOLD, 0);
    pose(5, 6);
    for (n = 0; n < 1450; n++) begin
      if (!sending && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      sending = ($urandom_range(0, 9) != 0);
      random_request();
      if (!sending) gap();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[waypoint_sequencer] OK");
    end else begin
      $display("[waypoint_sequencer] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[waypoint_sequencer] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wps_pkg.sv
hdl/wps_ram.sv
hdl/wps_datapath.sv
hdl/wps_controller.sv
hdl/waypoint_sequencer.sv
dv/waypoint_sequencer_checker.sv
dv/waypoint_sequencer_tb.sv
